// ===== src/tea_pkg.sv =====
// ----------------------------------------------------------------------------
// tea_pkg
// Shared types, constants and the round mixing function of the TEA core.
// ----------------------------------------------------------------------------
`default_nettype none

package tea_pkg;

  localparam int WORD_W         = 32;
  localparam int DEFAULT_ROUNDS = 32;
  localparam int CFG_ADDR_W     = 4;
  localparam int CFG_DATA_W     = 32;

  localparam logic [WORD_W-1:0] DELTA = 32'h9e37_79b9;

  // Request type carried in tuser.
  localparam logic REQ_ENCRYPT = 1'b0;
  localparam logic REQ_DECRYPT = 1'b1;

  // Register index, taken from paddr[3:2].
  typedef enum logic [1:0] {
    REG_KEY0 = 2'd0,
    REG_KEY1 = 2'd1,
    REG_KEY2 = 2'd2,
    REG_KEY3 = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [WORD_W-1:0] k3;
    logic [WORD_W-1:0] k2;
    logic [WORD_W-1:0] k1;
    logic [WORD_W-1:0] k0;
  } key_t;

  // Block in flight: operation plus the two halves.
  typedef struct packed {
    logic              dec;
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] z;
  } blk_t;

  // Result words only.
  typedef struct packed {
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] z;
  } res_t;

  function automatic logic [WORD_W-1:0] tea_mix(
    input logic [WORD_W-1:0] x,
    input logic [WORD_W-1:0] sum,
    input logic [WORD_W-1:0] kl,
    input logic [WORD_W-1:0] kr
  );
    return ((x << 4) + kl) ^ (x + sum) ^ ((x >> 5) + kr);
  endfunction

endpackage

`default_nettype wire

// ===== src/tea_block_cipher_core.sv =====
// ----------------------------------------------------------------------------
// tea_block_cipher_core
// TEA block cipher, one 64-bit block per beat, as a chain of half-round cells.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Content
//   in_       slave      tdata = first_half, second_half; tuser = req_type
//   out_      master     tdata = out_first_half, out_second_half
//   cfg_      APB        key_word0..3 at byte addresses 0, 4, 8, 12
//
// Throughput is one beat per cycle while the output does not stall. Each
// round is split over two cells (one per half update), and the output
// register follows the last cell. Reset clears the valid bits of all cells,
// the output and skid registers, and the key words. When out_tready is low,
// one more beat is caught in the skid entry and then the whole chain holds
// together, so in_tready falls in the cycle after the output stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module tea_block_cipher_core import tea_pkg::*; #(
  parameter int ROUNDS = DEFAULT_ROUNDS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Input stream.
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [63:0]           in_tdata,   // [31:0] first_half, [63:32] second_half
  input  wire logic                  in_tuser,   // [0] req_type (1 = decrypt)
  // Result stream.
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic      [63:0]           out_tdata,  // [31:0] out_first_half,
                                                 // [63:32] out_second_half
  // Key registers.
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [CFG_DATA_W-1:0] cfg_prdata,
  output logic                       cfg_pready
);

  localparam int CELLS = 2 * ROUNDS;

  key_t key;
  logic en;
  logic vld [0:CELLS];
  blk_t blk [0:CELLS];
  res_t res;

  tea_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .key     (key)
  );

  // Head of the chain is the input port itself.
  assign vld[0]    = in_tvalid;
  assign blk[0]    = '{dec: in_tuser, y: in_tdata[31:0], z: in_tdata[63:32]};
  assign in_tready = en;

  // Cell 2r does the first update of round r, cell 2r+1 the second.
  for (genvar c = 0; c < CELLS; c++) begin : g_cell
    tea_round_cell #(
      .ROUNDS     (ROUNDS),
      .ROUND_IDX  (c / 2),
      .FIRST_HALF ((c % 2) == 0)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .key       (key),
      .in_valid  (vld[c]),
      .in_blk    (blk[c]),
      .out_valid (vld[c+1]),
      .out_blk   (blk[c+1])
    );
  end

  tea_out_skid u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .pipe_valid (vld[CELLS]),
    .pipe_blk   (blk[CELLS]),
    .pipe_en    (en),
    .out_valid  (out_tvalid),
    .out_res    (res),
    .out_ready  (out_tready)
  );

  assign out_tdata = {res.z, res.y};

endmodule

`default_nettype wire

// ===== src/tea_round_cell.sv =====
// ----------------------------------------------------------------------------
// tea_round_cell
// One half round: updates one half of the block and registers the result.
// ----------------------------------------------------------------------------
`default_nettype none

module tea_round_cell import tea_pkg::*; #(
  parameter int ROUNDS     = DEFAULT_ROUNDS,
  parameter int ROUND_IDX  = 0,
  parameter bit FIRST_HALF = 1'b1
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic en,
  input  wire key_t key,
  input  wire logic in_valid,
  input  wire blk_t in_blk,
  output logic      out_valid,
  output blk_t      out_blk
);

  // Round sums are fixed per cell; encryption counts up, decryption down.
  localparam logic [63:0] ENC_SUM_W = 64'(DELTA) * 64'(ROUND_IDX + 1);
  localparam logic [63:0] DEC_SUM_W = 64'(DELTA) * 64'(ROUNDS - ROUND_IDX);
  localparam logic [WORD_W-1:0] ENC_SUM = ENC_SUM_W[WORD_W-1:0];
  localparam logic [WORD_W-1:0] DEC_SUM = DEC_SUM_W[WORD_W-1:0];

  logic              valid_r;
  blk_t              blk_r;
  blk_t              blk_nxt;
  logic              upd_y;
  logic [WORD_W-1:0] src;
  logic [WORD_W-1:0] tgt;
  logic [WORD_W-1:0] sum;
  logic [WORD_W-1:0] kl;
  logic [WORD_W-1:0] kr;
  logic [WORD_W-1:0] mixed;
  logic [WORD_W-1:0] upd;

  always_comb begin
    // Encryption updates y first, decryption updates z first.
    upd_y   = FIRST_HALF ? (in_blk.dec == REQ_ENCRYPT) : (in_blk.dec == REQ_DECRYPT);
    src     = upd_y ? in_blk.z : in_blk.y;
    tgt     = upd_y ? in_blk.y : in_blk.z;
    kl      = upd_y ? key.k0 : key.k2;
    kr      = upd_y ? key.k1 : key.k3;
    sum     = (in_blk.dec == REQ_DECRYPT) ? DEC_SUM : ENC_SUM;
    mixed   = tea_mix(src, sum, kl, kr);
    upd     = (in_blk.dec == REQ_DECRYPT) ? (tgt - mixed) : (tgt + mixed);
    blk_nxt = in_blk;
    if (upd_y) begin
      blk_nxt.y = upd;
    end else begin
      blk_nxt.z = upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      blk_r <= blk_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_blk   = blk_r;

endmodule

`default_nettype wire

// ===== src/tea_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// tea_cfg_regs
// APB key register file: four 32-bit key words.
// ----------------------------------------------------------------------------
`default_nettype none

module tea_cfg_regs import tea_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready,
  output key_t                       key
);

  key_t     key_r;
  reg_idx_t idx;
  logic     wr;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (wr) begin
      unique case (idx)
        REG_KEY0: key_r.k0 <= pwdata;
        REG_KEY1: key_r.k1 <= pwdata;
        REG_KEY2: key_r.k2 <= pwdata;
        REG_KEY3: key_r.k3 <= pwdata;
        default:  key_r    <= key_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_KEY0: prdata = key_r.k0;
      REG_KEY1: prdata = key_r.k1;
      REG_KEY2: prdata = key_r.k2;
      REG_KEY3: prdata = key_r.k3;
      default:  prdata = '0;
    endcase
  end

  assign key = key_r;

endmodule

`default_nettype wire

// ===== src/tea_out_skid.sv =====
// ----------------------------------------------------------------------------
// tea_out_skid
// Output register with a skid entry that decouples the cell chain from tready.
// ----------------------------------------------------------------------------
`default_nettype none

module tea_out_skid import tea_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic pipe_valid,
  input  wire blk_t pipe_blk,
  output logic      pipe_en,
  output logic      out_valid,
  output res_t      out_res,
  input  wire logic out_ready
);

  logic out_valid_r;
  res_t out_res_r;
  logic skid_valid_r;
  res_t skid_res_r;
  logic arrive;
  logic free;
  res_t pipe_res;

  // The chain moves only while the skid entry is empty.
  assign pipe_en  = !skid_valid_r;
  assign arrive   = pipe_valid && pipe_en;
  assign free     = !out_valid_r || out_ready;
  assign pipe_res = '{y: pipe_blk.y, z: pipe_blk.z};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (free) begin
      out_valid_r  <= skid_valid_r || arrive;
      skid_valid_r <= 1'b0;
    end else if (arrive) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (free) begin
      out_res_r <= skid_valid_r ? skid_res_r : pipe_res;
    end else if (arrive) begin
      skid_res_r <= pipe_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

`default_nettype wire

// ===== sim/tea_block_cipher_core_test.sv =====
// ----------------------------------------------------------------------------
// tea_block_cipher_core_test
// Self-checking testbench for the TEA block cipher core.
// ----------------------------------------------------------------------------
// A short table of directed blocks runs first under the all-zero reset key.
// It covers the published zero-key vector, the extremes of both halves, and
// both operations. Several key settings follow, each written over the
// configuration port while the core is idle. Under each setting a random
// stream runs, mostly encryptions and decryptions of recent ciphertexts, so
// that blocks go through whole round trips. Each result beat is checked
// against a behavioral TEA model kept in this file. Both stream sides idle
// at random, except during one phase that runs at full rate.
// ----------------------------------------------------------------------------
`default_nettype none

module tea_block_cipher_core_test;
  import tea_pkg::*;

  localparam int LATENCY      = 2 * DEFAULT_ROUNDS + 1;
  localparam int DRAIN_CYCLES = LATENCY + 8;
  localparam int STALL_LIMIT  = 2000;
  localparam int GAP_PERCENT  = 27;
  localparam int KEY_PHASES   = 6;
  localparam int PHASE_BLOCKS = 140;
  localparam int N_DIRECTED   = 12;
  localparam int HISTORY_MAX  = 16;

  // One directed block; known marks rows whose result is typed in.
  typedef struct packed {
    logic              dec;
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] z;
    logic              known;
    logic [WORD_W-1:0] exp_y;
    logic [WORD_W-1:0] exp_z;
  } block_row_t;

  localparam block_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    // Zero key, zero block: the standard TEA test vector, and its inverse.
    '{REQ_ENCRYPT, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h41ea_3a0a, 32'h94ba_a940},
    '{REQ_DECRYPT, 32'h41ea_3a0a, 32'h94ba_a940, 1'b1, 32'h0000_0000, 32'h0000_0000},
    '{REQ_ENCRYPT, 32'hffff_ffff, 32'hffff_ffff, 1'b0, 32'h0, 32'h0},
    '{REQ_DECRYPT, 32'hffff_ffff, 32'hffff_ffff, 1'b0, 32'h0, 32'h0},
    '{REQ_ENCRYPT, 32'h0000_0000, 32'hffff_ffff, 1'b0, 32'h0, 32'h0},
    '{REQ_ENCRYPT, 32'hffff_ffff, 32'h0000_0000, 1'b0, 32'h0, 32'h0},
    '{REQ_DECRYPT, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0, 32'h0},
    '{REQ_ENCRYPT, 32'h8000_0000, 32'h0000_0001, 1'b0, 32'h0, 32'h0},
    '{REQ_DECRYPT, 32'h0000_0001, 32'h8000_0000, 1'b0, 32'h0, 32'h0},
    '{REQ_ENCRYPT, 32'h7fff_ffff, 32'hffff_fffe, 1'b0, 32'h0, 32'h0},
    '{REQ_ENCRYPT, 32'h5555_5555, 32'haaaa_aaaa, 1'b0, 32'h0, 32'h0},
    '{REQ_DECRYPT, 32'haaaa_aaaa, 32'h5555_5555, 1'b0, 32'h0, 32'h0}
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [63:0]           in_tdata = '0;   // [31:0] first_half, [63:32] second_half
  logic                  in_tuser = 1'b0; // [0] req_type (1 = decrypt)
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [63:0]           out_tdata;       // [31:0] out_first_half, [63:32] out_second_half
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  key_t key_now = '0;          // key the core holds, as written so far
  res_t expected_blocks [$];   // results still owed by the core
  res_t recent_cipher [$];     // ciphertexts under the current key
  bit   gaps_on = 1'b1;
  int   mismatches = 0;
  int   quiet_cycles = 0;

  tea_block_cipher_core i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // One half-round term of the Feistel network.
  function automatic logic [WORD_W-1:0] round_term(
    input logic [WORD_W-1:0] x,
    input logic [WORD_W-1:0] s,
    input logic [WORD_W-1:0] ka,
    input logic [WORD_W-1:0] kb
  );
    return ((x << 4) + ka) ^ (x + s) ^ ((x >> 5) + kb);
  endfunction

  function automatic res_t tea_transform(
    input logic              dec,
    input logic [WORD_W-1:0] y_in,
    input logic [WORD_W-1:0] z_in,
    input key_t              key
  );
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] z;
    logic [WORD_W-1:0] s;
    res_t              r;
    y = y_in;
    z = z_in;
    if (dec == REQ_ENCRYPT) begin
      s = '0;
      for (int i = 0; i < DEFAULT_ROUNDS; i++) begin
        s = s + DELTA;
        y = y + round_term(z, s, key.k0, key.k1);
        z = z + round_term(y, s, key.k2, key.k3);
      end
    end else begin
      s = 32'(DELTA * DEFAULT_ROUNDS);
      for (int i = 0; i < DEFAULT_ROUNDS; i++) begin
        z = z - round_term(y, s, key.k2, key.k3);
        y = y - round_term(z, s, key.k0, key.k1);
        s = s - DELTA;
      end
    end
    r.y = y;
    r.z = z;
    return r;
  endfunction

  // Mostly random words, with the corner values mixed in now and then.
  function automatic logic [WORD_W-1:0] pick_word();
    logic [WORD_W-1:0] corners [5];
    corners = '{32'h0000_0000, 32'hffff_ffff, 32'h8000_0000, 32'h0000_0001,
                32'h7fff_ffff};
    if ($urandom_range(99) < 10) return corners[$urandom_range(4)];
    return $urandom();
  endfunction

  // Setup-then-access register write; the key model follows once the write lands.
  task automatic write_key(input reg_idx_t idx, input logic [WORD_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_KEY0: key_now.k0 = value;
      REG_KEY1: key_now.k1 = value;
      REG_KEY2: key_now.k2 = value;
      REG_KEY3: key_now.k3 = value;
      default: ;
    endcase
  endtask

  // Offers one block and returns at the edge where it is taken. The owed
  // result is queued there; a typed-in result replaces the prediction.
  task automatic send_block(
    input logic              dec,
    input logic [WORD_W-1:0] y,
    input logic [WORD_W-1:0] z,
    input logic              known,
    input res_t              typed
  );
    res_t r;
    while (gaps_on && $urandom_range(99) < GAP_PERCENT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= dec;
    in_tdata  <= {z, y};
    do @(posedge clk); while (!in_tready);
    r = known ? typed : tea_transform(dec, y, z, key_now);
    expected_blocks.push_back(r);
    if (dec == REQ_ENCRYPT) begin
      recent_cipher.push_back(r);
      if (recent_cipher.size() > HISTORY_MAX) void'(recent_cipher.pop_front());
    end
  endtask

  // Waits for every owed result, then lets the pipeline run empty.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_blocks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Sink side: random backpressure unless gaps are switched off.
  always @(posedge clk) begin
    out_tready <= !gaps_on || ($urandom_range(99) >= GAP_PERCENT);
  end

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_blocks.size() == 0) begin
        $error("out_tdata: no result expected, got %h", out_tdata);
        mismatches++;
      end else begin
        want = expected_blocks.pop_front();
        if (out_tdata[31:0] !== want.y) begin
          $error("out_first_half: expected %h, got %h", want.y, out_tdata[31:0]);
          mismatches++;
        end
        if (out_tdata[63:32] !== want.z) begin
          $error("out_second_half: expected %h, got %h", want.z, out_tdata[63:32]);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: any beat or register write restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    key_t       plan [KEY_PHASES];
    block_row_t row;
    res_t       typed;
    res_t       src;
    int         pick;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table under the reset key, which is all zeros.
    for (int i = 0; i < N_DIRECTED; i++) begin
      row     = DIRECTED_ROWS[i];
      typed.y = row.exp_y;
      typed.z = row.exp_z;
      send_block(row.dec, row.y, row.z, row.known, typed);
    end
    drain();

    // Key settings: both extremes, a mixed corner key and random keys.
    plan[0] = {32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff};
    plan[1] = {32'h7fff_ffff, 32'hffff_fffe, 32'h0000_0001, 32'h8000_0000};
    for (int p = 2; p < KEY_PHASES - 1; p++) begin
      plan[p] = {$urandom(), $urandom(), $urandom(), $urandom()};
    end
    plan[KEY_PHASES-1] = '0;

    for (int p = 0; p < KEY_PHASES; p++) begin
      write_key(REG_KEY0, plan[p].k0);
      write_key(REG_KEY1, plan[p].k1);
      write_key(REG_KEY2, plan[p].k2);
      write_key(REG_KEY3, plan[p].k3);
      recent_cipher.delete();
      // The corner-key phase runs back to back with no idling at all.
      gaps_on = (p != 1);
      for (int n = 0; n < PHASE_BLOCKS; n++) begin
        pick = $urandom_range(99);
        if (pick < 35 && recent_cipher.size() != 0) begin
          src = recent_cipher[$urandom_range(recent_cipher.size() - 1)];
          send_block(REQ_DECRYPT, src.y, src.z, 1'b0, typed);
        end else if (pick < 75) begin
          send_block(REQ_ENCRYPT, pick_word(), pick_word(), 1'b0, typed);
        end else begin
          send_block(REQ_DECRYPT, pick_word(), pick_word(), 1'b0, typed);
        end
      end
      drain();
      gaps_on = 1'b1;
    end

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
